// ===== design/assert_macros.svh =====
// assertion helpers shared by the flattener modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define GCBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define GCBF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/gcbf_pkg.sv =====
package gcbf_pkg;

  localparam int COORD_W         = 16;
  localparam int VERT_W          = 20;
  localparam int CNT_W           = 20;
  localparam int RECIP_W         = 32;
  localparam int DENS_W          = 5;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int MAX_SAMPLES_DEF = 61;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int PROD_W          = COORD_W + 1 + RECIP_W + 1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [VERT_W-1:0]  vert_t;

  localparam vert_t VERT_MAX = {1'b0, {(VERT_W-1){1'b1}}};
  localparam vert_t VERT_MIN = {1'b1, {(VERT_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN   = 3'd0,
    REG_Y_MIN   = 3'd1,
    REG_X_RECIP = 3'd2,
    REG_Y_RECIP = 3'd3,
    REG_DENSITY = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    coord_t              x_min;
    coord_t              y_min;
    logic [RECIP_W-1:0]  x_recip;
    logic [RECIP_W-1:0]  y_recip;
    logic [DENS_W-1:0]   density;
  } cfg_t;

  typedef struct packed {
    vert_t p0x;
    vert_t p0y;
    vert_t p1x;
    vert_t p1y;
    vert_t p2x;
    vert_t p2y;
    logic  cur_on;
    logic  emit_mid;
    logic  cend;
  } job_t;

  typedef struct packed {
    vert_t             vert_x;
    vert_t             vert_y;
    logic              is_count;
    logic [CNT_W-1:0]  vertex_count;
    logic              last;
  } res_t;

  // a/2 + b/2 with each half truncated toward zero
  function automatic coord_t half_sum(coord_t a, coord_t b);
    coord_t ha;
    coord_t hb;
    ha = (a >>> 1) + coord_t'(a[COORD_W-1] & a[0]);
    hb = (b >>> 1) + coord_t'(b[COORD_W-1] & b[0]);
    return ha + hb;
  endfunction

  function automatic vert_t sat_vert(logic signed [PROD_W-1:0] v);
    logic [PROD_W-VERT_W:0] top;
    top = v[PROD_W-1:VERT_W-1];
    if (top == '0 || top == '1) begin
      return v[VERT_W-1:0];
    end else if (v[PROD_W-1]) begin
      return VERT_MIN;
    end else begin
      return VERT_MAX;
    end
  endfunction

endpackage

// ===== design/glyph_contour_bezier_flattener.sv =====
// Contour flattener: turns contour points into normalized polyline vertices.
// Input side behaves as a queue: drive the point, its neighbours and flags,
// raise push; the item is taken on a clock edge with push high and full low.
// Result side behaves as a queue too: while empty is low the oldest result is
// on the vert/count ports; pop with empty low takes it. last marks the final
// result of an item; an item may give no result at all.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i), to
// be used only while no item is in flight.
// The front end normalizes the six coordinates with one shared multiplier,
// one per cycle, and hands the item to a two-entry queue. For a control
// point the back end runs two bit-serial square roots, then, when N is at
// least two, four bit-serial divisions by N^2, and then emits one result
// per cycle while the receiver takes them.
// If the receiver stalls, the single output register holds its result and
// the back end waits; the front end keeps filling the queue meanwhile.
// Reset empties the queue, clears the vertex counter and loads the default
// register values; no clearing pass is needed.
`include "assert_macros.svh"

module glyph_contour_bezier_flattener import gcbf_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  coord_t                prev_x_i,
  input  coord_t                prev_y_i,
  input  logic                  prev_on_i,
  input  coord_t                cur_x_i,
  input  coord_t                cur_y_i,
  input  logic                  cur_on_i,
  input  coord_t                next_x_i,
  input  coord_t                next_y_i,
  input  logic                  next_on_i,
  input  logic                  contour_end_i,
  output logic                  empty,
  input  logic                  pop,
  output vert_t                 vert_x_o,
  output vert_t                 vert_y_o,
  output logic                  is_count_o,
  output logic [CNT_W-1:0]      vertex_count_o,
  output logic                  last_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;
  job_t fe_job, q_job;
  logic fe_valid, q_full, q_empty, q_pop;
  res_t be_res, out_q;
  logic be_valid, out_valid_q, out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_min   <= '0;
      cfg_q.y_min   <= '0;
      cfg_q.x_recip <= RECIP_W'(65536);
      cfg_q.y_recip <= RECIP_W'(65536);
      cfg_q.density <= DENS_W'(20);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_X_MIN:   cfg_q.x_min   <= cfg_data_i[COORD_W-1:0];
        REG_Y_MIN:   cfg_q.y_min   <= cfg_data_i[COORD_W-1:0];
        REG_X_RECIP: cfg_q.x_recip <= cfg_data_i[RECIP_W-1:0];
        REG_Y_RECIP: cfg_q.y_recip <= cfg_data_i[RECIP_W-1:0];
        REG_DENSITY: cfg_q.density <= cfg_data_i[DENS_W-1:0];
        default: ;
      endcase
    end
  end

  gcbf_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .push_i        (push),
    .prev_x_i,
    .prev_y_i,
    .prev_on_i,
    .cur_x_i,
    .cur_y_i,
    .cur_on_i,
    .next_x_i,
    .next_y_i,
    .next_on_i,
    .contour_end_i,
    .cfg_i         (cfg_q),
    .full_o        (full),
    .job_o         (fe_job),
    .job_valid_o   (fe_valid),
    .job_full_i    (q_full)
  );

  gcbf_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (fe_valid),
    .job_i   (fe_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (q_job),
    .empty_o (q_empty)
  );

  gcbf_back #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .job_i       (q_job),
    .job_empty_i (q_empty),
    .job_pop_o   (q_pop),
    .density_i   (cfg_q.density),
    .res_o       (be_res),
    .res_valid_o (be_valid),
    .res_ready_i (out_ready)
  );

  assign out_ready = !out_valid_q || pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (be_valid && out_ready) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (be_valid && out_ready) begin
      out_q <= be_res;
    end
  end

  assign empty          = !out_valid_q;
  assign vert_x_o       = out_q.vert_x;
  assign vert_y_o       = out_q.vert_y;
  assign is_count_o     = out_q.is_count;
  assign vertex_count_o = out_q.vertex_count;
  assign last_o         = out_q.last;

  `GCBF_ASSERT(a_no_overwrite, (out_valid_q && !pop) |=> (out_valid_q && $stable(out_q)), "result register overwritten")

endmodule

// ===== design/gcbf_front.sv =====
module gcbf_front import gcbf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  coord_t prev_x_i,
  input  coord_t prev_y_i,
  input  logic   prev_on_i,
  input  coord_t cur_x_i,
  input  coord_t cur_y_i,
  input  logic   cur_on_i,
  input  coord_t next_x_i,
  input  coord_t next_y_i,
  input  logic   next_on_i,
  input  logic   contour_end_i,
  input  cfg_t   cfg_i,
  output logic   full_o,
  output job_t   job_o,
  output logic   job_valid_o,
  input  logic   job_full_i
);

  localparam int SH = RECIP_W - FRAC_BITS;

  typedef enum logic [1:0] {F_IDLE, F_NORM, F_PUSH} state_e;
  typedef enum logic [2:0] {N_P1X, N_P1Y, N_P0X, N_P0Y, N_P2X, N_P2Y} step_e;

  state_e state_q;
  step_e  step_q;
  coord_t px_q, py_q, cx_q, cy_q, nx_q, ny_q;
  logic   pon_q, non_q, con_q, cend_q;
  job_t   job_q;

  coord_t                    src;
  logic                      use_y;
  coord_t                    mn;
  logic [RECIP_W-1:0]        rc;
  logic signed [COORD_W:0]   diff;
  logic signed [PROD_W-1:0]  prod;
  vert_t                     nv;

  always_comb begin
    src   = cx_q;
    use_y = 1'b0;
    case (step_q)
      N_P1X: src = cx_q;
      N_P1Y: begin
        src   = cy_q;
        use_y = 1'b1;
      end
      N_P0X: src = pon_q ? px_q : half_sum(px_q, cx_q);
      N_P0Y: begin
        src   = pon_q ? py_q : half_sum(py_q, cy_q);
        use_y = 1'b1;
      end
      N_P2X: src = non_q ? nx_q : half_sum(nx_q, cx_q);
      N_P2Y: begin
        src   = non_q ? ny_q : half_sum(ny_q, cy_q);
        use_y = 1'b1;
      end
      default: src = cx_q;
    endcase
    mn   = use_y ? cfg_i.y_min : cfg_i.x_min;
    rc   = use_y ? cfg_i.y_recip : cfg_i.x_recip;
    diff = $signed({src[COORD_W-1], src}) - $signed({mn[COORD_W-1], mn});
    prod = diff * $signed({1'b0, rc});
    // arithmetic shift gives the floor
    nv   = sat_vert(prod >>> SH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= N_P1X;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (push_i) begin
            state_q <= F_NORM;
            step_q  <= N_P1X;
          end
        end
        F_NORM: begin
          if (step_q == N_P2Y) begin
            state_q <= F_PUSH;
          end else begin
            step_q <= step_e'(step_q + 3'd1);
          end
        end
        F_PUSH: begin
          if (!job_full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && push_i) begin
      px_q   <= prev_x_i;
      py_q   <= prev_y_i;
      pon_q  <= prev_on_i;
      cx_q   <= cur_x_i;
      cy_q   <= cur_y_i;
      con_q  <= cur_on_i;
      nx_q   <= next_x_i;
      ny_q   <= next_y_i;
      non_q  <= next_on_i;
      cend_q <= contour_end_i;
    end
    if (state_q == F_NORM) begin
      case (step_q)
        N_P1X:   job_q.p1x <= nv;
        N_P1Y:   job_q.p1y <= nv;
        N_P0X:   job_q.p0x <= nv;
        N_P0Y:   job_q.p0y <= nv;
        N_P2X:   job_q.p2x <= nv;
        N_P2Y:   job_q.p2y <= nv;
        default: job_q.p1x <= nv;
      endcase
      job_q.cur_on   <= con_q;
      job_q.emit_mid <= !con_q && !pon_q;
      job_q.cend     <= cend_q;
    end
  end

  assign full_o      = (state_q != F_IDLE);
  assign job_valid_o = (state_q == F_PUSH);
  assign job_o       = job_q;

endmodule

// ===== design/gcbf_queue.sv =====
`include "assert_macros.svh"

module gcbf_queue import gcbf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
  localparam logic [PW:0]   DEPTH_C  = (PW + 1)'(QUEUE_DEPTH);

  job_t            mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [PW:0]     cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == DEPTH_C);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (PW + 1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (PW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  `GCBF_ASSERT_ALWAYS(a_ptr_track, (cnt_q == '0) |-> (wr_q == rd_q), "queue empty but pointers differ")

endmodule

// ===== design/gcbf_back.sv =====
`include "assert_macros.svh"

module gcbf_back import gcbf_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  job_t              job_i,
  input  logic              job_empty_i,
  output logic              job_pop_o,
  input  logic [DENS_W-1:0] density_i,
  output res_t              res_o,
  output logic              res_valid_o,
  input  logic              res_ready_i
);

  localparam int NW     = $clog2(MAX_SAMPLES + 2);
  localparam int DW     = 2 * NW;
  localparam int DIFF_W = VERT_W + 1;
  localparam int DVD_W  = NW + VERT_W + 2;
  localparam int Q_W    = DVD_W + 1;
  localparam int DCW    = $clog2(DVD_W + 1);
  localparam int RAD_W  = 2 * DIFF_W;
  localparam int ROOT_W = DIFF_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int SCW    = $clog2(ROOT_W + 1);
  localparam int LEN_W  = ROOT_W + 1;
  localparam int NP_W   = LEN_W + DENS_W;
  localparam int C_W    = VERT_W + 3;
  localparam logic [NP_W-1:0] NSAT_WIDE = NP_W'(MAX_SAMPLES + 1);
  localparam logic [NW-1:0]   NSAT      = NW'(MAX_SAMPLES + 1);
  localparam logic [NW-1:0]   N_TWO     = NW'(2);
  localparam logic [DCW-1:0]  DIV_LAST  = DCW'(DVD_W - 1);
  localparam logic [SCW-1:0]  SQ_LAST   = SCW'(ROOT_W - 1);

  typedef enum logic [3:0] {
    B_IDLE, B_P1, B_SQ, B_SQRT, B_MULN, B_NSAT, B_DSQ,
    B_DLD, B_DIV, B_INIT, B_MID, B_SAMP, B_CNT
  } state_e;

  typedef enum logic [1:0] {D_AX, D_CX, D_AY, D_CY} div_sel_e;

  typedef struct packed {
    logic signed [Q_W-1:0] q;
    logic [DW-1:0]         r;
  } qr_t;

  // sum of two quotient/remainder pairs, remainder kept below d
  function automatic qr_t addqr(qr_t a, qr_t b, logic [DW-1:0] d);
    logic [DW:0] s;
    logic [DW:0] sd;
    qr_t         o;
    s  = {1'b0, a.r} + {1'b0, b.r};
    sd = s - {1'b0, d};
    if (s >= {1'b0, d}) begin
      o.r = sd[DW-1:0];
      o.q = a.q + b.q + Q_W'(1);
    end else begin
      o.r = s[DW-1:0];
      o.q = a.q + b.q;
    end
    return o;
  endfunction

  state_e             state_q;
  job_t               j_q;
  logic               seg_q, sq_y_q;
  logic [RAD_W-1:0]   rad_q;
  logic [REM_W-1:0]   rem_q;
  logic [ROOT_W-1:0]  root_q;
  logic [SCW-1:0]     sq_cnt_q;
  logic [LEN_W-1:0]   len_q;
  logic [NP_W-1:0]    np_q;
  logic [NW-1:0]      n_q, k_q;
  logic [DW-1:0]      d_q;
  div_sel_e           dv_idx_q;
  logic [DVD_W-1:0]   dv_m_q, dv_qt_q;
  logic [DW:0]        dv_r_q;
  logic [DCW-1:0]     dv_cnt_q;
  logic               dv_neg_q;
  qr_t                divr_q [4];
  qr_t                ex_q, fx_q, tx_q, ey_q, fy_q, ty_q;
  logic [CNT_W-1:0]   cv_q;

  // squares
  vert_t                     sa, sb;
  logic signed [DIFF_W-1:0]  sd;
  logic signed [RAD_W-1:0]   sq;
  // square root step
  logic [REM_W-1:0]          rem_sh, trial, rem_nx;
  logic                      sq_ge;
  logic [ROOT_W-1:0]         root_nx;
  // sample count
  logic [NP_W-1:0]           nsh;
  // divider operand
  vert_t                     op0, op1, op2;
  logic signed [DIFF_W-1:0]  dp;
  logic signed [NW+DIFF_W+1:0] prod_a;
  logic signed [C_W-1:0]     cc;
  logic signed [DVD_W-1:0]   dvd;
  logic [DVD_W-1:0]          dvd_mag;
  // divider step
  logic [DW:0]               r_sh, r_nx;
  logic                      dv_ge;
  logic [DVD_W-1:0]          q_nx;
  qr_t                       dv_res;
  // sampling
  qr_t                       ex_new, fx_new, ey_new, fy_new;
  logic signed [Q_W-1:0]     smp_x, smp_y;
  logic                      fire;

  always_comb begin
    sa = seg_q ? j_q.p1x : j_q.p0x;
    sb = seg_q ? j_q.p2x : j_q.p1x;
    if (sq_y_q) begin
      sa = seg_q ? j_q.p1y : j_q.p0y;
      sb = seg_q ? j_q.p2y : j_q.p1y;
    end
    sd = DIFF_W'(sb) - DIFF_W'(sa);
    sq = sd * sd;

    // one result bit per cycle
    rem_sh  = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
    trial   = REM_W'({root_q, 2'b01});
    sq_ge   = (rem_sh >= trial);
    rem_nx  = sq_ge ? rem_sh - trial : rem_sh;
    root_nx = {root_q[ROOT_W-2:0], sq_ge};

    nsh = np_q >> FRAC_BITS;

    // dividends: A = 2N(p1-p0), C = p0 - 2p1 + p2
    op0 = j_q.p0x;
    op1 = j_q.p1x;
    op2 = j_q.p2x;
    if (dv_idx_q == D_AY || dv_idx_q == D_CY) begin
      op0 = j_q.p0y;
      op1 = j_q.p1y;
      op2 = j_q.p2y;
    end
    dp     = DIFF_W'(op1) - DIFF_W'(op0);
    prod_a = $signed({1'b0, n_q, 1'b0}) * dp;
    cc     = C_W'(op0) - (C_W'(op1) <<< 1) + C_W'(op2);
    if (dv_idx_q == D_AX || dv_idx_q == D_AY) begin
      dvd = prod_a[DVD_W-1:0];
    end else begin
      dvd = DVD_W'(cc);
    end
    dvd_mag = dvd[DVD_W-1] ? DVD_W'(-dvd) : DVD_W'(dvd);

    r_sh  = {dv_r_q[DW-1:0], dv_m_q[DVD_W-1]};
    dv_ge = (r_sh >= {1'b0, d_q});
    r_nx  = dv_ge ? r_sh - {1'b0, d_q} : r_sh;
    q_nx  = {dv_qt_q[DVD_W-2:0], dv_ge};
    // floor division for negative dividends
    if (dv_neg_q && r_nx[DW-1:0] != '0) begin
      dv_res.q = -$signed({1'b0, q_nx}) - Q_W'(1);
      dv_res.r = d_q - r_nx[DW-1:0];
    end else if (dv_neg_q) begin
      dv_res.q = -$signed({1'b0, q_nx});
      dv_res.r = '0;
    end else begin
      dv_res.q = $signed({1'b0, q_nx});
      dv_res.r = r_nx[DW-1:0];
    end

    ex_new = addqr(ex_q, fx_q, d_q);
    fx_new = addqr(fx_q, tx_q, d_q);
    ey_new = addqr(ey_q, fy_q, d_q);
    fy_new = addqr(fy_q, ty_q, d_q);
    smp_x  = Q_W'(j_q.p0x) + ex_new.q;
    smp_y  = Q_W'(j_q.p0y) + ey_new.q;

    res_o       = '0;
    res_valid_o = 1'b0;
    job_pop_o   = 1'b0;
    unique case (state_q)
      B_IDLE: job_pop_o = !job_empty_i;
      B_P1: begin
        res_valid_o  = 1'b1;
        res_o.vert_x = j_q.p1x;
        res_o.vert_y = j_q.p1y;
        res_o.last   = !j_q.cend;
      end
      B_MID: begin
        res_valid_o  = 1'b1;
        res_o.vert_x = j_q.p0x;
        res_o.vert_y = j_q.p0y;
        res_o.last   = !j_q.cend && (n_q < N_TWO);
      end
      B_SAMP: begin
        res_valid_o  = 1'b1;
        res_o.vert_x = smp_x[VERT_W-1:0];
        res_o.vert_y = smp_y[VERT_W-1:0];
        res_o.last   = !j_q.cend && (k_q == n_q - NW'(1));
      end
      B_CNT: begin
        res_valid_o        = 1'b1;
        res_o.is_count     = 1'b1;
        res_o.vertex_count = cv_q;
        res_o.last         = 1'b1;
      end
      default: res_valid_o = 1'b0;
    endcase
    fire = res_valid_o && res_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      j_q      <= '0;
      seg_q    <= 1'b0;
      sq_y_q   <= 1'b0;
      rad_q    <= '0;
      rem_q    <= '0;
      root_q   <= '0;
      sq_cnt_q <= '0;
      len_q    <= '0;
      np_q     <= '0;
      n_q      <= '0;
      k_q      <= '0;
      d_q      <= '0;
      dv_idx_q <= D_AX;
      dv_m_q   <= '0;
      dv_qt_q  <= '0;
      dv_r_q   <= '0;
      dv_cnt_q <= '0;
      dv_neg_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        divr_q[i] <= '0;
      end
      ex_q     <= '0;
      fx_q     <= '0;
      tx_q     <= '0;
      ey_q     <= '0;
      fy_q     <= '0;
      ty_q     <= '0;
      cv_q     <= '0;
    end else begin
      if (fire) begin
        if (res_o.is_count) begin
          cv_q <= '0;
        end else if (cv_q != CNT_MAX) begin
          cv_q <= cv_q + CNT_W'(1);
        end
      end
      unique case (state_q)
        B_IDLE: begin
          if (!job_empty_i) begin
            j_q     <= job_i;
            seg_q   <= 1'b0;
            sq_y_q  <= 1'b0;
            state_q <= job_i.cur_on ? B_P1 : B_SQ;
          end
        end
        B_P1: begin
          if (fire) begin
            state_q <= j_q.cend ? B_CNT : B_IDLE;
          end
        end
        B_SQ: begin
          if (!sq_y_q) begin
            rad_q  <= sq;
            sq_y_q <= 1'b1;
          end else begin
            rad_q    <= rad_q + sq;
            sq_y_q   <= 1'b0;
            rem_q    <= '0;
            root_q   <= '0;
            sq_cnt_q <= '0;
            state_q  <= B_SQRT;
          end
        end
        B_SQRT: begin
          rad_q    <= rad_q << 2;
          rem_q    <= rem_nx;
          root_q   <= root_nx;
          sq_cnt_q <= sq_cnt_q + SCW'(1);
          if (sq_cnt_q == SQ_LAST) begin
            len_q <= seg_q ? len_q + LEN_W'(root_nx) : LEN_W'(root_nx);
            if (seg_q) begin
              state_q <= B_MULN;
            end else begin
              seg_q   <= 1'b1;
              state_q <= B_SQ;
            end
          end
        end
        B_MULN: begin
          np_q    <= len_q * density_i;
          state_q <= B_NSAT;
        end
        B_NSAT: begin
          n_q     <= (nsh > NSAT_WIDE) ? NSAT : nsh[NW-1:0];
          state_q <= B_DSQ;
        end
        B_DSQ: begin
          d_q <= n_q * n_q;
          if (n_q < N_TWO) begin
            if (j_q.emit_mid) begin
              state_q <= B_MID;
            end else begin
              state_q <= j_q.cend ? B_CNT : B_IDLE;
            end
          end else begin
            dv_idx_q <= D_AX;
            state_q  <= B_DLD;
          end
        end
        B_DLD: begin
          dv_m_q   <= dvd_mag;
          dv_neg_q <= dvd[DVD_W-1];
          dv_r_q   <= '0;
          dv_qt_q  <= '0;
          dv_cnt_q <= '0;
          state_q  <= B_DIV;
        end
        B_DIV: begin
          dv_m_q   <= dv_m_q << 1;
          dv_r_q   <= r_nx;
          dv_qt_q  <= q_nx;
          dv_cnt_q <= dv_cnt_q + DCW'(1);
          if (dv_cnt_q == DIV_LAST) begin
            divr_q[dv_idx_q] <= dv_res;
            if (dv_idx_q == D_CY) begin
              state_q <= B_INIT;
            end else begin
              dv_idx_q <= div_sel_e'(dv_idx_q + 2'd1);
              state_q  <= B_DLD;
            end
          end
        end
        B_INIT: begin
          // forward differences of E(k) = kA + k^2 C, kept as quotient and remainder
          ex_q    <= '0;
          ey_q    <= '0;
          fx_q    <= addqr(divr_q[D_AX], divr_q[D_CX], d_q);
          tx_q    <= addqr(divr_q[D_CX], divr_q[D_CX], d_q);
          fy_q    <= addqr(divr_q[D_AY], divr_q[D_CY], d_q);
          ty_q    <= addqr(divr_q[D_CY], divr_q[D_CY], d_q);
          k_q     <= NW'(1);
          state_q <= j_q.emit_mid ? B_MID : B_SAMP;
        end
        B_MID: begin
          if (fire) begin
            if (n_q >= N_TWO) begin
              state_q <= B_SAMP;
            end else begin
              state_q <= j_q.cend ? B_CNT : B_IDLE;
            end
          end
        end
        B_SAMP: begin
          if (fire) begin
            ex_q <= ex_new;
            fx_q <= fx_new;
            ey_q <= ey_new;
            fy_q <= fy_new;
            if (k_q == n_q - NW'(1)) begin
              state_q <= j_q.cend ? B_CNT : B_IDLE;
            end else begin
              k_q <= k_q + NW'(1);
            end
          end
        end
        B_CNT: begin
          if (fire) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  `GCBF_ASSERT(a_samp_idx, (state_q == B_SAMP) |-> (k_q != '0 && k_q < n_q), "sample index out of range")
  `GCBF_ASSERT(a_rem_range, (state_q == B_SAMP) |-> (ex_q.r < d_q && fx_q.r < d_q && ty_q.r < d_q), "remainder not below divisor")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import gcbf_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int HOLD_CYCLES    = 1500;
  localparam int RANDOM_POINTS  = 480;
  localparam int NUM_PHASES     = 6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SAMPLES_CAP    = MAX_SAMPLES_DEF + 1;

  typedef struct {
    coord_t px, py, cx, cy, nx, ny;
    logic   pon, con, non, cend;
  } point_t;

  class flatten_scoreboard;
    cfg_t               cfg;
    logic [CNT_W-1:0]   contour_vertices;
    res_t               pending[$];
    int                 errors;

    function new();
      cfg.x_min = '0;
      cfg.y_min = '0;
      cfg.x_recip = 32'd65536;
      cfg.y_recip = 32'd65536;
      cfg.density = 5'd20;
      contour_vertices = '0;
      errors = 0;
    endfunction

    function longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    function vert_t normalize(int v, int mn, logic [31:0] r);
      longint p;
      p = longint'(v - mn) * longint'({32'd0, r});
      p = p >>> (32 - FRAC_BITS_DEF);
      if (p > 524287) p = 524287;
      if (p < -524288) p = -524288;
      return vert_t'(p);
    endfunction

    function int halves(coord_t a, coord_t b);
      return int'(a) / 2 + int'(b) / 2;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint unsigned span(vert_t ax, vert_t ay, vert_t bx, vert_t by);
      longint dx, dy;
      dx = longint'(bx) - longint'(ax);
      dy = longint'(by) - longint'(ay);
      return root(longint'(dx * dx + dy * dy));
    endfunction

    function void add_vertex(ref res_t items[$], input longint x, input longint y);
      res_t r;
      r = '0;
      r.vert_x = vert_t'(x);
      r.vert_y = vert_t'(y);
      items.push_back(r);
      if (contour_vertices != CNT_MAX) contour_vertices++;
    endfunction

    function void note_point(point_t pt);
      res_t items[$];
      res_t r;
      vert_t p0x, p0y, p1x, p1y, p2x, p2y;
      longint unsigned len, n;
      longint w0, w1, w2, d;
      if (pt.con) begin
        add_vertex(items, normalize(pt.cx, cfg.x_min, cfg.x_recip),
                   normalize(pt.cy, cfg.y_min, cfg.y_recip));
      end else begin
        p1x = normalize(pt.cx, cfg.x_min, cfg.x_recip);
        p1y = normalize(pt.cy, cfg.y_min, cfg.y_recip);
        if (pt.pon) begin
          p0x = normalize(pt.px, cfg.x_min, cfg.x_recip);
          p0y = normalize(pt.py, cfg.y_min, cfg.y_recip);
        end else begin
          // implied midpoint goes out ahead of the samples
          p0x = normalize(halves(pt.px, pt.cx), cfg.x_min, cfg.x_recip);
          p0y = normalize(halves(pt.py, pt.cy), cfg.y_min, cfg.y_recip);
          add_vertex(items, p0x, p0y);
        end
        if (pt.non) begin
          p2x = normalize(pt.nx, cfg.x_min, cfg.x_recip);
          p2y = normalize(pt.ny, cfg.y_min, cfg.y_recip);
        end else begin
          p2x = normalize(halves(pt.nx, pt.cx), cfg.x_min, cfg.x_recip);
          p2y = normalize(halves(pt.ny, pt.cy), cfg.y_min, cfg.y_recip);
        end
        len = span(p0x, p0y, p1x, p1y) + span(p1x, p1y, p2x, p2y);
        n = (len * cfg.density) >> FRAC_BITS_DEF;
        if (n > SAMPLES_CAP) n = SAMPLES_CAP;
        for (longint k = 1; k < longint'(n); k++) begin
          w0 = (longint'(n) - k) * (longint'(n) - k);
          w1 = 2 * k * (longint'(n) - k);
          w2 = k * k;
          d = longint'(n) * longint'(n);
          add_vertex(items, fdiv(w0 * p0x + w1 * p1x + w2 * p2x, d),
                     fdiv(w0 * p0y + w1 * p1y + w2 * p2y, d));
        end
      end
      if (pt.cend) begin
        r = '0;
        r.is_count = 1'b1;
        r.vertex_count = contour_vertices;
        items.push_back(r);
        contour_vertices = '0;
      end
      if (items.size() > 0) items[items.size()-1].last = 1'b1;
      foreach (items[i]) pending.push_back(items[i]);
    endfunction

    function void check_result(res_t got);
      res_t exp;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.vert_x !== exp.vert_x) begin
        $error("vert_x: expected %0d, got %0d", exp.vert_x, got.vert_x); errors++;
      end
      if (got.vert_y !== exp.vert_y) begin
        $error("vert_y: expected %0d, got %0d", exp.vert_y, got.vert_y); errors++;
      end
      if (got.is_count !== exp.is_count) begin
        $error("is_count: expected %0d, got %0d", exp.is_count, got.is_count); errors++;
      end
      if (got.vertex_count !== exp.vertex_count) begin
        $error("vertex_count: expected %0d, got %0d", exp.vertex_count, got.vertex_count);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic push, full, empty, pop;
  coord_t prev_x_i, prev_y_i, cur_x_i, cur_y_i, next_x_i, next_y_i;
  logic prev_on_i, cur_on_i, next_on_i, contour_end_i;
  vert_t vert_x_o, vert_y_o;
  logic is_count_o, last_o;
  logic [CNT_W-1:0] vertex_count_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  flatten_scoreboard sb = new();
  int points_in, results_out, idle_cycles, cyc;

  glyph_contour_bezier_flattener dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // beat monitor, sampled at the edge before any update lands
  always @(posedge clk_i) begin
    point_t pt;
    res_t r;
    cyc++;
    idle_cycles++;
    if (rst_ni && push && !full) begin
      pt.px = prev_x_i; pt.py = prev_y_i; pt.pon = prev_on_i;
      pt.cx = cur_x_i;  pt.cy = cur_y_i;  pt.con = cur_on_i;
      pt.nx = next_x_i; pt.ny = next_y_i; pt.non = next_on_i;
      pt.cend = contour_end_i;
      sb.note_point(pt);
      points_in++;
      idle_cycles = 0;
    end
    if (rst_ni && pop && !empty) begin
      r.vert_x = vert_x_o; r.vert_y = vert_y_o; r.is_count = is_count_o;
      r.vertex_count = vertex_count_o; r.last = last_o;
      sb.check_result(r);
      results_out++;
      idle_cycles = 0;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: changing stall pattern, plus one long hold-off to fill the block
  initial begin
    bit held;
    held = 0;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && points_in >= 60) begin
        held = 1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        case ((cyc >> 8) % 3)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          default: pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  int burst_left;

  task automatic offer(point_t pt);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    push <= 1'b1;
    prev_x_i <= pt.px; prev_y_i <= pt.py; prev_on_i <= pt.pon;
    cur_x_i <= pt.cx;  cur_y_i <= pt.cy;  cur_on_i <= pt.con;
    next_x_i <= pt.nx; next_y_i <= pt.ny; next_on_i <= pt.non;
    contour_end_i <= pt.cend;
    do @(posedge clk_i); while (full);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    // a point may still be in flight with no result
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_X_MIN:   sb.cfg.x_min = data[15:0];
      REG_Y_MIN:   sb.cfg.y_min = data[15:0];
      REG_X_RECIP: sb.cfg.x_recip = data;
      REG_Y_RECIP: sb.cfg.y_recip = data;
      REG_DENSITY: sb.cfg.density = data[DENS_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_setting(int phase);
    case (phase)
      1: begin
        write_reg(REG_X_MIN, 32'hFFFF_8000); write_reg(REG_Y_MIN, 32'h0000_7FFF);
        write_reg(REG_X_RECIP, 32'd65536); write_reg(REG_Y_RECIP, 32'd65536);
        write_reg(REG_DENSITY, 32'd22);
      end
      2: begin
        write_reg(REG_X_MIN, 32'h0000_7FFF); write_reg(REG_Y_MIN, 32'hFFFF_8000);
        write_reg(REG_X_RECIP, 32'hFFFF_FFFF); write_reg(REG_Y_RECIP, 32'd0);
        write_reg(REG_DENSITY, 32'd1);
      end
      3: begin
        write_reg(REG_X_MIN, 32'd0); write_reg(REG_Y_MIN, 32'd0);
        write_reg(REG_X_RECIP, 32'h0002_0000); write_reg(REG_Y_RECIP, 32'h0000_8000);
        write_reg(REG_DENSITY, 32'd0);
      end
      4: begin
        write_reg(REG_X_MIN, 32'hFFFF_FC18); write_reg(REG_Y_MIN, 32'd500);
        write_reg(REG_X_RECIP, 32'h0001_2345); write_reg(REG_Y_RECIP, 32'h000A_BCDE);
        write_reg(REG_DENSITY, 32'd31);
      end
      default: begin
        write_reg(REG_X_MIN, 32'd0); write_reg(REG_Y_MIN, 32'd0);
        write_reg(REG_X_RECIP, 32'd65536); write_reg(REG_Y_RECIP, 32'd65536);
        write_reg(REG_DENSITY, 32'd20);
        // index past the list, must be ignored
        write_reg(REG_UNUSED, 32'd3);
      end
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic point_t mk(int px, int py, bit pon, int cx, int cy, bit con,
                                int nx, int ny, bit non, bit cend);
    point_t p;
    p.px = px; p.py = py; p.pon = pon; p.cx = cx; p.cy = cy; p.con = con;
    p.nx = nx; p.ny = ny; p.non = non; p.cend = cend;
    return p;
  endfunction

  function automatic point_t noise_point();
    point_t p;
    {p.px, p.py, p.cx, p.cy} = {$urandom(), $urandom()};
    {p.nx, p.ny} = $urandom();
    {p.pon, p.con, p.non, p.cend} = 4'($urandom());
    return p;
  endfunction

  // one closed contour with random geometry, points offered in order
  task automatic send_contour(ref int budget);
    int len, spread;
    coord_t xs[8], ys[8];
    bit on[8];
    coord_t bx, by;
    len = $urandom_range(1, 8);
    case ($urandom_range(0, 3))
      0: spread = 16;
      1: spread = 2000;
      2: spread = 20000;
      default: spread = 65535;
    endcase
    bx = $urandom(); by = $urandom();
    for (int i = 0; i < len; i++) begin
      xs[i] = bx + coord_t'($urandom_range(0, spread));
      ys[i] = by + coord_t'($urandom_range(0, spread));
      on[i] = $urandom_range(0, 2) == 0;
    end
    for (int i = 0; i < len && budget > 0; i++) begin
      int pi, ni;
      pi = (i + len - 1) % len;
      ni = (i + 1) % len;
      offer(mk(xs[pi], ys[pi], on[pi], xs[i], ys[i], on[i], xs[ni], ys[ni], on[ni],
               i == len - 1));
      budget--;
    end
  endtask

  initial begin
    point_t directed[$];
    int budget;
    push = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    prev_x_i = '0; prev_y_i = '0; cur_x_i = '0; cur_y_i = '0; next_x_i = '0; next_y_i = '0;
    prev_on_i = 1'b0; cur_on_i = 1'b0; next_on_i = 1'b0; contour_end_i = 1'b0;
    burst_left = 0;
    @(posedge rst_ni);
    @(posedge clk_i);

    directed = '{
      mk(0, 0, 1, -32768, -32768, 1, 0, 0, 1, 0),
      mk(0, 0, 1, 32767, 32767, 1, 0, 0, 1, 1),
      mk(0, 0, 1, 30000, 0, 0, 30000, 30000, 1, 0),
      mk(-3, -5, 0, -7, -9, 0, 30001, 29999, 1, 0),
      mk(-32768, 32767, 0, 32767, -32768, 0, -32768, -32768, 0, 1),
      mk(100, 100, 1, 100, 100, 0, 100, 100, 1, 0),
      mk(100, 100, 1, 100, 100, 0, 100, 100, 1, 1),
      mk(5, 5, 0, 7, 7, 0, 9, 9, 0, 0),
      mk(0, 0, 1, 1000, 0, 0, 2000, 0, 0, 0),
      mk(-20000, 0, 1, 0, 20000, 0, 20000, 0, 1, 1),
      mk(32767, 32767, 1, -32768, -32768, 0, 32767, 32767, 1, 1),
      mk(0, 0, 0, 0, 0, 1, 0, 0, 0, 1),
      mk(-1, -1, 0, 1, 1, 0, -1, -1, 0, 1)
    };
    foreach (directed[i]) offer(directed[i]);
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) load_setting(ph);
      budget = RANDOM_POINTS / NUM_PHASES;
      while (budget > 0) begin
        if ($urandom_range(0, 9) == 0) begin
          offer(noise_point());
          budget--;
        end else begin
          send_contour(budget);
        end
      end
      settle();
    end

    $display("covered %0d points and %0d result beats over %0d register settings",
             points_in, results_out, NUM_PHASES);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("mismatches: %0d", sb.errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
